>>> hw/rtl/clipped_alpha_sprite_blit_macros.svh
// ----------------------------------------------------------------------------
// clipped_alpha_sprite_blit_macros
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef CLIPPED_ALPHA_SPRITE_BLIT_MACROS_SVH
`define CLIPPED_ALPHA_SPRITE_BLIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CASB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, disabled while in reset
`define CASB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> hw/rtl/casb_pkg.sv
// ----------------------------------------------------------------------------
// casb_pkg
// shared types, codes and helpers of the sprite blitter
// ----------------------------------------------------------------------------
`default_nettype none

package casb_pkg;

  localparam int FB_AW    = 16;
  localparam int FB_DEPTH = 1 << FB_AW;
  localparam int PIX_W    = 32;
  localparam int CFG_W    = 11;
  localparam int CNT_W    = 10;
  localparam int ST_W     = 3;
  localparam int MAX_SIZE = 1024;

  localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;

  typedef enum logic [1:0] {
    CMD_PIXEL    = 2'd0,
    CMD_LOAD     = 2'd1,
    CMD_READ     = 2'd2,
    CMD_READ_ALT = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OPAQUE  = 3'd0,
    ST_BLEND   = 3'd1,
    ST_CLEAR   = 3'd2,
    ST_CLIPPED = 3'd3,
    ST_IO_DONE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_DEST_X  = 2'd0,
    REG_DEST_Y  = 2'd1,
    REG_WIDTH   = 2'd2,
    REG_HEIGHT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_LOAD  = 3'd1,
    OP_COPY  = 3'd2,
    OP_BLEND = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef struct packed {
    logic             en;
    logic [FB_AW-1:0] addr;
    logic [PIX_W-1:0] data;
  } fb_wr_t;

  typedef struct packed {
    logic             en;
    logic [FB_AW-1:0] addr;
  } fb_rd_t;

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > CFG_W'(MAX_SIZE)) begin
      r = CFG_W'(MAX_SIZE);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/clipped_alpha_sprite_blit.sv
// ----------------------------------------------------------------------------
// clipped_alpha_sprite_blit
// alpha sprite blitter over an in-block ARGB8888 framebuffer
// ----------------------------------------------------------------------------
// s_* carries commands: a sprite pixel (tuser 0), a framebuffer load (1) or
// a framebuffer read (2 or 3). Sprite pixels come in row-major order; the
// block counts source column and row, clips against the screen and copies,
// blends or skips. Every word in gives exactly one word out on m_*: read
// data in tdata, status in tuser, last pixel of the sprite on tlast.
// The framebuffer read and the stage 1 registers are loaded when a word is
// accepted; blend, write-back and the output register load happen when
// stage 1 advances, and m_tvalid then rises. Throughput: one word per clock
// while m_tready is high; a read-modify-write that hits the word written
// just ahead of it is forwarded.
// Reset clears the position counters, the handshake state and the registers
// (corner 0,0 and size 1x1); framebuffer contents are undefined until loaded,
// and there is no clearing pass. A configuration write restarts the
// position counters. When m_tready is low the result waits in the output
// register, one more word waits in the blend stage, and s_tready then drops.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_alpha_sprite_blit #(
  parameter int SCREEN_COLUMNS = 256,
  parameter int SCREEN_ROWS    = 256
) (
  input  wire         clk,
  input  wire         rst,
  // config write port
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [10:0] cfg_data,
  // command stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [47:0] s_tdata,   // pixel[31:0], fb_addr[47:32]
  input  wire  [1:0]  s_tuser,   // cmd[1:0]
  // result stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // read_data[31:0]
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast    // sprite_done
);
  import casb_pkg::*;

  localparam int POS_W = CFG_W + 1;
  localparam logic [POS_W-1:0] COL_LIM = POS_W'(SCREEN_COLUMNS);
  localparam logic [POS_W-1:0] ROW_LIM = POS_W'(SCREEN_ROWS);

  // configuration registers and position counters
  logic [CFG_W-1:0] dest_x, dest_y, sprite_width, sprite_height;
  logic [CNT_W-1:0] src_col, src_row;

  // stage 0 decode
  cmd_t             cmd;
  logic [PIX_W-1:0] pix;
  logic [FB_AW-1:0] io_addr;
  logic             accept;
  logic [CFG_W-1:0] w_eff, h_eff;
  logic [POS_W-1:0] sx, sy;
  logic             clipped;
  logic [31:0]      fa_full;
  logic [FB_AW-1:0] addr0;
  logic [7:0]       alpha;
  op_t              op0;
  status_t          status0;
  logic             last_col, last_row, done0;

  // stage 1
  logic             s1_valid;
  op_t              s1_op;
  status_t          s1_status;
  logic             s1_done;
  logic [FB_AW-1:0] s1_addr;
  logic [PIX_W-1:0] s1_pix;
  logic             fwd_hit;
  logic [PIX_W-1:0] fwd_data;
  logic             s1_adv;
  logic [PIX_W-1:0] rdata, dst, blended;
  fb_wr_t           wr;
  fb_rd_t           rd;
  logic [PIX_W-1:0] s1_read_data;

  // output register
  logic             out_valid;

  assign cmd     = cmd_t'(s_tuser);
  assign pix     = s_tdata[PIX_W-1:0];
  assign io_addr = s_tdata[PIX_W +: FB_AW];

  assign s1_adv   = !out_valid || m_tready;
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    w_eff    = clamp_size(sprite_width);
    h_eff    = clamp_size(sprite_height);
    sx       = {dest_x[CFG_W-1], dest_x} + POS_W'(src_col);
    sy       = {dest_y[CFG_W-1], dest_y} + POS_W'(src_row);
    clipped  = sx[POS_W-1] || sy[POS_W-1] || (sx >= COL_LIM) || (sy >= ROW_LIM);
    fa_full  = 32'(sy[CFG_W-1:0]) * 32'(SCREEN_COLUMNS) + 32'(sx[CFG_W-1:0]);
    alpha    = pix[PIX_W-1 -: 8];
    last_col = (CFG_W'(src_col) + CFG_W'(1)) >= w_eff;
    last_row = (CFG_W'(src_row) + CFG_W'(1)) >= h_eff;
  end

  always_comb begin
    op0     = OP_NOP;
    status0 = ST_IO_DONE;
    done0   = 1'b0;
    addr0   = io_addr;
    case (cmd)
      CMD_LOAD: begin
        op0 = OP_LOAD;
      end
      CMD_READ, CMD_READ_ALT: begin
        op0 = OP_READ;
      end
      CMD_PIXEL: begin
        addr0 = fa_full[FB_AW-1:0];
        done0 = last_col && last_row;
        if (clipped) begin
          status0 = ST_CLIPPED;
        end else if (alpha == 8'h00) begin
          status0 = ST_CLEAR;
        end else if (alpha == 8'hFF) begin
          op0     = OP_COPY;
          status0 = ST_OPAQUE;
        end else begin
          op0     = OP_BLEND;
          status0 = ST_BLEND;
        end
      end
      default: begin
        op0 = OP_READ;
      end
    endcase
  end

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x        <= '0;
      dest_y        <= '0;
      sprite_width  <= CFG_W'(1);
      sprite_height <= CFG_W'(1);
      src_col       <= '0;
      src_row       <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEST_X: dest_x        <= cfg_data;
        REG_DEST_Y: dest_y        <= cfg_data;
        REG_WIDTH:  sprite_width  <= cfg_data;
        REG_HEIGHT: sprite_height <= cfg_data;
        default:    dest_x        <= dest_x;
      endcase
      src_col <= '0;
      src_row <= '0;
    end else if (accept && cmd == CMD_PIXEL) begin
      if (last_col) begin
        src_col <= '0;
        src_row <= last_row ? '0 : src_row + CNT_W'(1);
      end else begin
        src_col <= src_col + CNT_W'(1);
      end
    end
  end

  // framebuffer read issued on accept
  assign rd.en   = accept;
  assign rd.addr = addr0;

  casb_fb_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= op0;
      s1_status <= status0;
      s1_done   <= done0;
      s1_addr   <= addr0;
      s1_pix    <= pix;
      // the write leaving stage 1 at this edge is not yet seen by the read
      fwd_hit   <= wr.en && (wr.addr == addr0);
      fwd_data  <= wr.data;
    end
  end

  assign dst = fwd_hit ? fwd_data : rdata;

  casb_blend u_blend (
    .src    (s1_pix),
    .dst    (dst),
    .result (blended)
  );

  always_comb begin
    wr.en        = 1'b0;
    wr.addr      = s1_addr;
    wr.data      = s1_pix;
    s1_read_data = '0;
    case (s1_op)
      OP_LOAD: begin
        wr.en = s1_valid && s1_adv;
      end
      OP_COPY: begin
        wr.en   = s1_valid && s1_adv;
        wr.data = s1_pix | ALPHA_OPAQUE;
      end
      OP_BLEND: begin
        wr.en   = s1_valid && s1_adv;
        wr.data = blended;
      end
      OP_READ: begin
        s1_read_data = dst;
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      m_tdata <= s1_read_data;
      m_tuser <= s1_status;
      m_tlast <= s1_done;
    end
  end

  assign m_tvalid = out_valid;

endmodule

`default_nettype wire

>>> hw/rtl/casb_fb_ram.sv
// ----------------------------------------------------------------------------
// casb_fb_ram
// framebuffer store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module casb_fb_ram (
  input  wire                       clk,
  input  casb_pkg::fb_wr_t          wr,
  input  casb_pkg::fb_rd_t          rd,
  output logic [casb_pkg::PIX_W-1:0] rdata
);
  import casb_pkg::*;

  logic [PIX_W-1:0] mem [FB_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read returns the word as it was before a write at the same edge
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/casb_blend.sv
// ----------------------------------------------------------------------------
// casb_blend
// per-channel alpha blend of a source pixel over a destination word
// ----------------------------------------------------------------------------
`default_nettype none

module casb_blend (
  input  wire  [casb_pkg::PIX_W-1:0] src,
  input  wire  [casb_pkg::PIX_W-1:0] dst,
  output logic [casb_pkg::PIX_W-1:0] result
);
  import casb_pkg::*;

  localparam int CH_W   = 8;
  localparam int NCH    = 3;
  localparam int SUM_W  = 2 * CH_W + 1;

  logic [CH_W-1:0] alpha;
  logic [CH_W-1:0] alpha_inv;

  assign alpha     = src[PIX_W-1 -: CH_W];
  assign alpha_inv = ~alpha;  // 255 - a

  for (genvar c = 0; c < NCH; c++) begin : g_ch
    logic [SUM_W-1:0] sum;
    assign sum = SUM_W'(src[c*CH_W +: CH_W]) * SUM_W'(alpha)
               + SUM_W'(dst[c*CH_W +: CH_W]) * SUM_W'(alpha_inv)
               + SUM_W'(128);
    assign result[c*CH_W +: CH_W] = sum[2*CH_W-1:CH_W];
  end

  assign result[PIX_W-1 -: CH_W] = ALPHA_OPAQUE[PIX_W-1 -: CH_W];

endmodule

`default_nettype wire

>>> hw/rtl/casb_checker.sv
// ----------------------------------------------------------------------------
// casb_checker
// port-level checks on the blitter's result stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "clipped_alpha_sprite_blit_macros.svh"

module casb_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [31:0] m_tdata,
  input wire [2:0]  m_tuser,
  input wire        m_tlast
);
  import casb_pkg::*;

  // a stalled word holds
  `CASB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))

  // only a read carries data
  `CASB_ASSERT_NOW(a_data_zero, m_tvalid && (m_tuser != ST_IO_DONE), m_tdata == 32'd0)

  // end of sprite comes only with a sprite pixel
  `CASB_ASSERT_NOW(a_last_pixel, m_tvalid && m_tlast, m_tuser != ST_IO_DONE)

  // status never goes past the load/read code
  `CASB_ASSERT_NOW(a_status_range, m_tvalid, m_tuser <= ST_IO_DONE)

endmodule

bind clipped_alpha_sprite_blit casb_checker u_casb_checker (.*);

`default_nettype wire
